### rtl/token_classifier_counter_unit_defines.svh
// assertion macros for the token classifier counter unit
// used by the rtl modules that carry concurrent checks, no other dependencies
`ifndef TOKEN_CLASSIFIER_COUNTER_UNIT_DEFINES_SVH
`define TOKEN_CLASSIFIER_COUNTER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define TCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcc check failed");

// next-cycle implication, disabled while in reset
`define TCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcc check failed");

`endif

### rtl/tcc_pkg.sv
// shared types, codes and keyword table for the token classifier counter unit
// no dependencies
`default_nettype none

package tcc_pkg;

    localparam int DEFAULT_COUNT_WIDTH = 8;
    localparam int KW_MAX_LEN          = 8;
    localparam int KW_COUNT            = 32;
    localparam int OUT_CNT_WIDTH       = 8;

    typedef enum logic [2:0] {
        CLASS_KEYWORD    = 3'd0,
        CLASS_CONSTANT   = 3'd1,
        CLASS_IDENT      = 3'd2,
        CLASS_RELATIONAL = 3'd3,
        CLASS_OTHER      = 3'd4
    } tok_class_t;

    typedef enum logic {
        KIND_TOKEN  = 1'b0,
        KIND_TOTALS = 1'b1
    } result_kind_t;

    typedef struct packed {
        logic token_done;
        logic line_done;
    } tcc_flags_t;

    typedef struct packed {
        tok_class_t                 cls;
        logic [OUT_CNT_WIDTH-1:0]   keyword_total;
        logic [OUT_CNT_WIDTH-1:0]   identifier_total;
        logic [OUT_CNT_WIDTH-1:0]   constant_total;
        logic [OUT_CNT_WIDTH-1:0]   arith_total;
        logic [OUT_CNT_WIDTH-1:0]   relational_total;
        logic [OUT_CNT_WIDTH-1:0]   bracket_total;
        logic [OUT_CNT_WIDTH-1:0]   punct_total;
    } tcc_result_t;

    // keywords right-justified, first character in the highest used byte
    localparam logic [8*KW_MAX_LEN-1:0] KW_WORDS [KW_COUNT] = '{
        64'("auto"),     64'("break"),    64'("case"),     64'("char"),
        64'("const"),    64'("continue"), 64'("default"),  64'("do"),
        64'("double"),   64'("else"),     64'("enum"),     64'("extern"),
        64'("float"),    64'("for"),      64'("goto"),     64'("if"),
        64'("int"),      64'("long"),     64'("register"), 64'("return"),
        64'("short"),    64'("signed"),   64'("sizeof"),   64'("static"),
        64'("struct"),   64'("switch"),   64'("typedef"),  64'("union"),
        64'("unsigned"), 64'("void"),     64'("volatile"), 64'("while")
    };

    localparam logic [3:0] KW_LENS [KW_COUNT] = '{
        4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2,
        4'd6, 4'd4, 4'd4, 4'd6, 4'd5, 4'd3, 4'd4, 4'd2,
        4'd3, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6,
        4'd6, 4'd6, 4'd7, 4'd5, 4'd8, 4'd4, 4'd8, 4'd5
    };

    localparam logic [7:0] CH_UNDERSCORE = "_";
    localparam logic [7:0] CH_PLUS       = "+";
    localparam logic [7:0] CH_MINUS      = "-";
    localparam logic [7:0] CH_STAR       = "*";
    localparam logic [7:0] CH_SLASH      = "/";
    localparam logic [7:0] CH_LPAREN     = "(";
    localparam logic [7:0] CH_RPAREN     = ")";
    localparam logic [7:0] CH_LBRACE     = "{";
    localparam logic [7:0] CH_RBRACE     = "}";
    localparam logic [7:0] CH_LBRACKET   = "[";
    localparam logic [7:0] CH_RBRACKET   = "]";
    localparam logic [7:0] CH_SEMI       = ";";
    localparam logic [7:0] CH_COMMA      = ",";
    localparam logic [7:0] CH_COLON      = ":";
    localparam logic [7:0] CH_PERIOD     = ".";
    localparam logic [7:0] CH_GT         = ">";
    localparam logic [7:0] CH_LT         = "<";
    localparam logic [7:0] CH_EQ         = "=";
    localparam logic [7:0] CH_BANG       = "!";
    localparam logic [7:0] CH_SPACE      = " ";
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_CR         = 8'h0D;

endpackage

`default_nettype wire

### rtl/tcc_token_unit.sv
// token state, per-byte flags, classification and saturating line totals
// depends on tcc_pkg
`default_nettype none

module tcc_token_unit #(
    parameter int COUNT_WIDTH = tcc_pkg::DEFAULT_COUNT_WIDTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic [7:0]           text_byte,
    input  logic                 end_of_line,
    output tcc_pkg::tcc_flags_t  flags,
    output tcc_pkg::tcc_result_t result
);
    import tcc_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);
    localparam logic [3:0]             LEN_CAP = 4'd15;
    localparam int PEND_ARITH   = 0;
    localparam int PEND_BRACKET = 1;
    localparam int PEND_PUNCT   = 2;
    localparam int TOT_KEYWORD  = 0;
    localparam int TOT_IDENT    = 1;
    localparam int TOT_CONST    = 2;
    localparam int TOT_ARITH    = 3;
    localparam int TOT_REL      = 4;
    localparam int TOT_BRACKET  = 5;
    localparam int TOT_PUNCT    = 6;

    function automatic logic [COUNT_WIDTH-1:0] sat_add(
        input logic [COUNT_WIDTH-1:0] a,
        input logic [COUNT_WIDTH-1:0] b
    );
        logic [COUNT_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_WIDTH] ? CNT_MAX : s[COUNT_WIDTH-1:0];
    endfunction

    function automatic logic [OUT_CNT_WIDTH-1:0] low_byte(input logic [COUNT_WIDTH-1:0] v);
        logic [15:0] w;
        w = 16'(v);
        return w[OUT_CNT_WIDTH-1:0];
    endfunction

    logic [7:0]             text_reg   [KW_MAX_LEN];
    logic [7:0]             text_next  [KW_MAX_LEN];
    logic [3:0]             len_reg, len_next, len_upd;
    logic                   inside_reg, inside_next, inside_upd;
    logic                   digits_reg, digits_next, digits_upd;
    logic                   ident_reg, ident_next, ident_upd;
    logic [COUNT_WIDTH-1:0] pend_reg   [3];
    logic [COUNT_WIDTH-1:0] pend_next  [3];
    logic [COUNT_WIDTH-1:0] pend_upd   [3];
    logic [COUNT_WIDTH-1:0] tot_reg    [7];
    logic [COUNT_WIDTH-1:0] tot_next   [7];
    logic [COUNT_WIDTH-1:0] tot_upd    [7];

    logic                      is_space, is_digit, is_alpha;
    logic                      closing;
    logic [8*KW_MAX_LEN-1:0]   tok_word;
    logic                      kw_hit, rel_hit;
    tok_class_t                cls;

    assign is_space = (text_byte == CH_SPACE) || (text_byte >= CH_TAB && text_byte <= CH_CR);
    assign is_digit = (text_byte >= "0") && (text_byte <= "9");
    assign is_alpha = ((text_byte >= "a") && (text_byte <= "z"))
                   || ((text_byte >= "A") && (text_byte <= "Z"));

    // byte joins the open token
    always_comb
    begin
        text_next  = text_reg;
        len_upd    = len_reg;
        inside_upd = inside_reg;
        digits_upd = digits_reg;
        ident_upd  = ident_reg;
        pend_upd   = pend_reg;
        if (!is_space)
        begin
            if (len_reg < 4'(KW_MAX_LEN))
                text_next[len_reg[2:0]] = text_byte;
            if (len_reg == 4'd0 && is_digit)
                ident_upd = 1'b0;
            if (!is_digit)
                digits_upd = 1'b0;
            if (!is_digit && !is_alpha && text_byte != CH_UNDERSCORE)
                ident_upd = 1'b0;
            if (text_byte == CH_PLUS || text_byte == CH_MINUS ||
                text_byte == CH_STAR || text_byte == CH_SLASH)
                pend_upd[PEND_ARITH] = sat_add(pend_reg[PEND_ARITH], CNT_ONE);
            else if (text_byte == CH_LPAREN || text_byte == CH_RPAREN ||
                     text_byte == CH_LBRACE || text_byte == CH_RBRACE ||
                     text_byte == CH_LBRACKET || text_byte == CH_RBRACKET)
                pend_upd[PEND_BRACKET] = sat_add(pend_reg[PEND_BRACKET], CNT_ONE);
            else if (text_byte == CH_SEMI || text_byte == CH_COMMA ||
                     text_byte == CH_COLON || text_byte == CH_PERIOD)
                pend_upd[PEND_PUNCT] = sat_add(pend_reg[PEND_PUNCT], CNT_ONE);
            if (len_reg < LEN_CAP)
                len_upd = len_reg + 4'd1;
            inside_upd = 1'b1;
        end
    end

    assign closing = inside_upd && (is_space || end_of_line);

    // token text packed right-justified for the keyword compare
    always_comb
    begin
        tok_word = '0;
        for (int i = 0; i < KW_MAX_LEN; i++)
        begin
            if (4'(i) < len_upd)
                tok_word = {tok_word[8*KW_MAX_LEN-9:0], text_next[i]};
        end
    end

    always_comb
    begin
        kw_hit = 1'b0;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            if (KW_LENS[k] == len_upd && KW_WORDS[k] == tok_word)
                kw_hit = 1'b1;
        end
    end

    always_comb
    begin
        rel_hit = 1'b0;
        if (len_upd == 4'd1)
            rel_hit = (text_next[0] == CH_GT) || (text_next[0] == CH_LT);
        else if (len_upd == 4'd2)
            rel_hit = (text_next[1] == CH_EQ) &&
                      ((text_next[0] == CH_GT) || (text_next[0] == CH_LT) ||
                       (text_next[0] == CH_EQ) || (text_next[0] == CH_BANG));
    end

    always_comb
    begin
        cls     = CLASS_OTHER;
        tot_upd = tot_reg;
        if (closing)
        begin
            priority if (kw_hit)
            begin
                cls                  = CLASS_KEYWORD;
                tot_upd[TOT_KEYWORD] = sat_add(tot_reg[TOT_KEYWORD], CNT_ONE);
            end
            else if (digits_upd)
            begin
                cls                = CLASS_CONSTANT;
                tot_upd[TOT_CONST] = sat_add(tot_reg[TOT_CONST], CNT_ONE);
            end
            else if (ident_upd)
            begin
                cls                = CLASS_IDENT;
                tot_upd[TOT_IDENT] = sat_add(tot_reg[TOT_IDENT], CNT_ONE);
            end
            else if (rel_hit)
            begin
                cls              = CLASS_RELATIONAL;
                tot_upd[TOT_REL] = sat_add(tot_reg[TOT_REL], CNT_ONE);
            end
            else
            begin
                cls                  = CLASS_OTHER;
                tot_upd[TOT_ARITH]   = sat_add(tot_reg[TOT_ARITH], pend_upd[PEND_ARITH]);
                tot_upd[TOT_BRACKET] = sat_add(tot_reg[TOT_BRACKET], pend_upd[PEND_BRACKET]);
                tot_upd[TOT_PUNCT]   = sat_add(tot_reg[TOT_PUNCT], pend_upd[PEND_PUNCT]);
            end
        end
    end

    always_comb
    begin
        len_next    = len_upd;
        inside_next = inside_upd;
        digits_next = digits_upd;
        ident_next  = ident_upd;
        pend_next   = pend_upd;
        tot_next    = tot_upd;
        if (closing)
        begin
            len_next    = 4'd0;
            inside_next = 1'b0;
            digits_next = 1'b1;
            ident_next  = 1'b1;
            pend_next   = '{default: '0};
        end
        if (end_of_line)
            tot_next = '{default: '0};
    end

    assign flags.token_done = closing;
    assign flags.line_done  = end_of_line;

    assign result.cls              = cls;
    assign result.keyword_total    = low_byte(tot_upd[TOT_KEYWORD]);
    assign result.identifier_total = low_byte(tot_upd[TOT_IDENT]);
    assign result.constant_total   = low_byte(tot_upd[TOT_CONST]);
    assign result.arith_total      = low_byte(tot_upd[TOT_ARITH]);
    assign result.relational_total = low_byte(tot_upd[TOT_REL]);
    assign result.bracket_total    = low_byte(tot_upd[TOT_BRACKET]);
    assign result.punct_total      = low_byte(tot_upd[TOT_PUNCT]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            inside_reg <= 1'b0;
            digits_reg <= 1'b1;
            ident_reg  <= 1'b1;
            pend_reg   <= '{default: '0};
            tot_reg    <= '{default: '0};
        end
        else if (load)
        begin
            len_reg    <= len_next;
            inside_reg <= inside_next;
            digits_reg <= digits_next;
            ident_reg  <= ident_next;
            pend_reg   <= pend_next;
            tot_reg    <= tot_next;
        end
    end

    // token text holds no reset, entries are read only once written
    always_ff @(posedge clk)
    begin
        if (load)
            text_reg <= text_next;
    end

endmodule

`default_nettype wire

### rtl/token_classifier_counter_unit.sv
// top level of the token classifier counter unit: input register, result pair register
// depends on tcc_pkg, tcc_token_unit and token_classifier_counter_unit_defines.svh
//
//   channel | dir | tdata                               | tuser       | tlast
//   s_*     | in  | text_byte                           | -           | end_of_line
//   m_*     | out | token_class, seven totals, 5'b0 pad | result_kind | last_of_run
//
// one byte a cycle while the m side takes each result: the byte waits in the input
// register, then the token unit classifies it and loads the result pair register
// in a single pass; a byte that ends a token and the line gives two requests,
// and meanwhile one further byte can wait in the input register
// rst_n clears all handshake state, token flags and line totals
// a stalled m side holds the pair register and, one byte later, s_tready drops
`default_nettype none
`include "token_classifier_counter_unit_defines.svh"

module token_classifier_counter_unit #(
    parameter int COUNT_WIDTH = tcc_pkg::DEFAULT_COUNT_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [2:0] token_class, [10:3] keyword_total,
                                   // [18:11] identifier_total, [26:19] constant_total,
                                   // [34:27] arith_total, [42:35] relational_total,
                                   // [50:43] bracket_total, [58:51] punct_total
    output logic [0:0]  m_tuser,   // [0] result_kind
    output logic        m_tlast
);
    import tcc_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_eol_reg;
    logic        tok_pend_reg, tot_pend_reg;
    tcc_result_t res_reg;
    tcc_flags_t  unit_flags;
    tcc_result_t unit_result;
    logic        pop, pair_free, in_advance;
    tok_class_t  out_cls;
    result_kind_t out_kind;

    tcc_token_unit #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_token (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (in_advance),
        .text_byte   (in_byte_reg),
        .end_of_line (in_eol_reg),
        .flags       (unit_flags),
        .result      (unit_result)
    );

    assign pop        = m_tvalid && m_tready;
    assign pair_free  = !(tok_pend_reg || tot_pend_reg) ||
                        (pop && !(tok_pend_reg && tot_pend_reg));
    assign in_advance = in_valid_reg && pair_free;
    assign s_tready   = !in_valid_reg || in_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_valid_reg <= 1'b1;
        else if (in_advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_eol_reg  <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_pend_reg <= 1'b0;
            tot_pend_reg <= 1'b0;
        end
        else if (in_advance)
        begin
            tok_pend_reg <= unit_flags.token_done;
            tot_pend_reg <= unit_flags.line_done;
        end
        else if (pop)
        begin
            if (tok_pend_reg)
                tok_pend_reg <= 1'b0;
            else
                tot_pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_advance)
            res_reg <= unit_result;
    end

    // token request goes first, totals follow
    assign out_kind = tok_pend_reg ? KIND_TOKEN : KIND_TOTALS;
    assign out_cls  = tok_pend_reg ? res_reg.cls : CLASS_KEYWORD;

    assign m_tvalid = tok_pend_reg || tot_pend_reg;
    assign m_tlast  = !(tok_pend_reg && tot_pend_reg);
    assign m_tuser  = out_kind;
    assign m_tdata  = {5'b0,
                       res_reg.punct_total,
                       res_reg.bracket_total,
                       res_reg.relational_total,
                       res_reg.arith_total,
                       res_reg.constant_total,
                       res_reg.identifier_total,
                       res_reg.keyword_total,
                       out_cls};

    `TCC_ASSERT_NOW(a_totals_last, clk, rst_n,
        m_tvalid && m_tuser == KIND_TOTALS, m_tlast)
    `TCC_ASSERT_NOW(a_totals_class, clk, rst_n,
        m_tvalid && m_tuser == KIND_TOTALS, m_tdata[2:0] == CLASS_KEYWORD)
    `TCC_ASSERT_NEXT(a_token_then_totals, clk, rst_n,
        m_tvalid && m_tready && m_tuser == KIND_TOKEN && !m_tlast,
        m_tvalid && m_tuser == KIND_TOTALS)
    `TCC_ASSERT_NOW(a_no_load_when_pair_full, clk, rst_n,
        tok_pend_reg && tot_pend_reg, !in_advance)

endmodule

`default_nettype wire
